/* hdl/dftme_pkg.sv */
// ----------------------------------------------------------------------------
// dftme_pkg
// Shared types and constants of the DFT matrix entry generator.
// ----------------------------------------------------------------------------
package dftme_pkg;

  // field widths
  localparam int IDX_W      = 12;
  localparam int N_W        = 13;
  localparam int SCALE_W    = 15;
  localparam int CFG_DATA_W = 15;
  localparam int PHASE_W    = 16;
  localparam int PROD_W     = 2 * IDX_W;
  localparam int DIV_STEPS  = PROD_W + PHASE_W;

  // fixed point trig datapath, unsigned Q1.30, square Q2.30
  localparam int X_W    = 31;
  localparam int X2_W   = 32;
  localparam int TRIG_W = 31;
  localparam logic [TRIG_W-1:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [32:0]       TWO_PI_Q30 = 33'd6746518852;

  // series terms, Horner order
  localparam int SIN_TERMS = 6;
  localparam int COS_TERMS = 7;
  localparam int TERM_LAT  = 3;
  localparam int SIN_DEN [SIN_TERMS] = '{156, 110, 72, 42, 20, 6};
  localparam int COS_DEN [COS_TERMS] = '{182, 132, 90, 56, 30, 12, 2};

  // defaults of the top level parameters
  localparam int DEF_MAX_ORDER   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // register map
  typedef enum logic [0:0] {
    CFG_SIZE_N     = 1'b0,
    CFG_NORM_SCALE = 1'b1
  } cfg_reg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              err;
  } item_t;

endpackage

/* hdl/dftme_if.sv */
// ----------------------------------------------------------------------------
// dftme interfaces
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface dftme_in_if;
  import dftme_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  modport source (output valid, row_index, col_index, input ready);
  modport sink (input valid, row_index, col_index, output ready);
endinterface

interface dftme_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] real_part;
  logic signed [W-1:0] imag_part;
  logic                index_error;
  modport source (output valid, real_part, imag_part, index_error, input ready);
  modport sink (input valid, real_part, imag_part, index_error, output ready);
endinterface

interface dftme_cfg_if;
  import dftme_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/dftme_front.sv */
// ----------------------------------------------------------------------------
// dftme_front
// Accepts index pairs, forms the index product and flags bad indices.
// ----------------------------------------------------------------------------
module dftme_front import dftme_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  dftme_in_if.sink       req,
  input  logic [N_W-1:0] n_eff,
  output item_t          item,
  output logic           item_valid,
  input  logic           item_ready
);

  logic take;

  assign req.ready = !item_valid || item_ready;
  assign take      = req.valid && req.ready;

  // holding register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  // product and range check of the accepted beat
  always_ff @(posedge clk) begin
    if (take) begin
      item.prod <= {{IDX_W{1'b0}}, req.row_index} * {{IDX_W{1'b0}}, req.col_index};
      item.err  <= (n_eff == '0) || ({1'b0, req.row_index} >= n_eff)
                   || ({1'b0, req.col_index} >= n_eff);
    end
  end

endmodule

/* hdl/dftme_fifo.sv */
// ----------------------------------------------------------------------------
// dftme_fifo
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module dftme_fifo import dftme_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t push_item,
  input  logic  push_valid,
  output logic  push_ready,
  output item_t pop_item,
  output logic  pop_valid,
  input  logic  pop_ready
);

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

/* hdl/dftme_term.sv */
// ----------------------------------------------------------------------------
// dftme_term
// One Horner step of the series: t' = 1 - ((x2 * t) >> 30) / DEN.
// ----------------------------------------------------------------------------
module dftme_term import dftme_pkg::*; #(
  parameter int DEN   = 6,
  parameter bit CLAMP = 1'b0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [X2_W-1:0]   x2_in,
  input  logic [TRIG_W-1:0] t_in,
  output logic [X2_W-1:0]   x2_out,
  output logic [TRIG_W-1:0] t_out
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DEN);
  localparam logic [7:0]  DEN_C = 8'(DEN);

  logic [62:0]       prod;
  logic [X2_W-1:0]   x2_a;
  logic [31:0]       v;
  logic [63:0]       vm;
  logic [X2_W-1:0]   x2_b;
  logic [31:0]       quo0;
  logic [31:0]       rem;
  logic [31:0]       quo;
  logic [TRIG_W-1:0] t_new;

  // quotient from reciprocal, then one correction step
  always_comb begin
    quo0 = vm[63:32];
    rem  = v - 32'({8'b0, quo0} * {32'b0, DEN_C});
    quo  = (rem >= {24'b0, DEN_C}) ? quo0 + 32'd1 : quo0;
    if (CLAMP && (quo >= {1'b0, ONE_Q30})) begin
      t_new = '0;
    end else begin
      t_new = ONE_Q30 - quo[TRIG_W-1:0];
    end
  end

  // three stage step
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= {31'b0, x2_in} * {32'b0, t_in};
      x2_a   <= x2_in;
      v      <= prod[61:30];
      vm     <= {32'b0, prod[61:30]} * {32'b0, RECIP};
      x2_b   <= x2_a;
      t_out  <= t_new;
      x2_out <= x2_b;
    end
  end

endmodule

/* hdl/dftme_back.sv */
// ----------------------------------------------------------------------------
// dftme_back
// Phase divider, sine and cosine series, scaling and output register.
// ----------------------------------------------------------------------------
module dftme_back import dftme_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [N_W-1:0]     n_eff,
  input  logic [SCALE_W-1:0] norm_scale,
  input  item_t              item,
  input  logic               item_valid,
  output logic               item_ready,
  dftme_out_if.source        rsp
);

  localparam int SIN_LAT  = SIN_TERMS * TERM_LAT;
  localparam int TRIG_LAT = COS_TERMS * TERM_LAT;
  localparam int BACK_LAT = DIV_STEPS + 2 + TRIG_LAT + 2;
  localparam int MP_W     = TRIG_W + SCALE_W;
  localparam int SH       = 46 - SAMPLE_BITS;
  localparam int MAG_W    = MP_W + 1 - SH;
  localparam logic [MAG_W-1:0] OUT_MAX = MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [MP_W:0]    RND     = (MP_W+1)'(64'd1 << (SH - 1));

  logic                en;
  logic                take;
  logic [BACK_LAT-1:0] vld;

  assign en         = !rsp.valid || rsp.ready;
  assign item_ready = en;
  assign take       = en && item_valid;
  assign rsp.valid  = vld[BACK_LAT-1];

  // valid line through the whole pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_LAT-2:0], take};
    end
  end

  // restoring divider: (i*j) mod n, then (k*2^16 + n/2) / n
  logic [N_W-1:0]       dv_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_d [DIV_STEPS];
  logic [PHASE_W-1:0]   dv_q [DIV_STEPS];
  logic                 dv_e [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [N_W-1:0]       r_i;
    logic [DIV_STEPS-1:0] d_i;
    logic [PHASE_W-1:0]   q_i;
    logic                 e_i;
    logic [N_W:0]         rr;
    logic                 ge;
    if (g == 0) begin : g_first
      assign r_i = '0;
      assign d_i = {item.prod, PHASE_W'(n_eff >> 1)};
      assign q_i = '0;
      assign e_i = item.err;
    end else begin : g_next
      assign r_i = dv_r[g-1];
      assign d_i = dv_d[g-1];
      assign q_i = dv_q[g-1];
      assign e_i = dv_e[g-1];
    end
    assign rr = {r_i, d_i[DIV_STEPS-1]};
    assign ge = (rr >= {1'b0, n_eff});
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g] <= ge ? N_W'(rr - {1'b0, n_eff}) : rr[N_W-1:0];
        dv_d[g] <= d_i << 1;
        dv_q[g] <= {q_i[PHASE_W-2:0], ge};
        dv_e[g] <= e_i;
      end
    end
  end

  // angle within the quadrant, then its square
  logic [PHASE_W-1:0] p;
  logic [46:0]        xm;
  logic [61:0]        x2m;
  logic [X_W-1:0]     x1;
  logic [1:0]         quad1;
  logic               e1;
  logic [X_W-1:0]     xp2;
  logic [X2_W-1:0]    x2;
  logic [1:0]         quad2;
  logic               e2;

  assign p   = dv_q[DIV_STEPS-1];
  assign xm  = {33'b0, p[PHASE_W-3:0]} * {14'b0, TWO_PI_Q30};
  assign x2m = {31'b0, x1} * {31'b0, x1};

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= xm[46:16];
      quad1 <= p[PHASE_W-1:PHASE_W-2];
      e1    <= dv_e[DIV_STEPS-1];
      xp2   <= x1;
      x2    <= x2m[61:30];
      quad2 <= quad1;
      e2    <= e1;
    end
  end

  // cosine series
  logic [X2_W-1:0]   cos_x2 [COS_TERMS+1];
  logic [TRIG_W-1:0] cos_t  [COS_TERMS+1];
  assign cos_x2[0] = x2;
  assign cos_t[0]  = ONE_Q30;
  for (genvar g = 0; g < COS_TERMS; g++) begin : g_cos
    dftme_term #(.DEN(COS_DEN[g]), .CLAMP(1'b1)) u_term (
      .clk    (clk),
      .en     (en),
      .x2_in  (cos_x2[g]),
      .t_in   (cos_t[g]),
      .x2_out (cos_x2[g+1]),
      .t_out  (cos_t[g+1])
    );
  end

  // sine series
  logic [X2_W-1:0]   sin_x2 [SIN_TERMS+1];
  logic [TRIG_W-1:0] sin_t  [SIN_TERMS+1];
  assign sin_x2[0] = x2;
  assign sin_t[0]  = ONE_Q30;
  for (genvar g = 0; g < SIN_TERMS; g++) begin : g_sin
    dftme_term #(.DEN(SIN_DEN[g]), .CLAMP(1'b0)) u_term (
      .clk    (clk),
      .en     (en),
      .x2_in  (sin_x2[g]),
      .t_in   (sin_t[g]),
      .x2_out (sin_x2[g+1]),
      .t_out  (sin_t[g+1])
    );
  end

  // side band alignment with the series
  logic [X_W-1:0] x_dly [SIN_LAT];
  logic [1:0]     q_dly [TRIG_LAT];
  logic           e_dly [TRIG_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      x_dly[0] <= xp2;
      for (int i = 1; i < SIN_LAT; i++) x_dly[i] <= x_dly[i-1];
      q_dly[0] <= quad2;
      e_dly[0] <= e2;
      for (int i = 1; i < TRIG_LAT; i++) begin
        q_dly[i] <= q_dly[i-1];
        e_dly[i] <= e_dly[i-1];
      end
    end
  end

  // final sine product and padding up to the cosine latency
  logic [61:0]       sm;
  logic [TRIG_W-1:0] s_fin;
  logic [TRIG_W-1:0] s_p1;
  logic [TRIG_W-1:0] s_p2;

  assign sm = {31'b0, x_dly[SIN_LAT-1]} * {31'b0, sin_t[SIN_TERMS]};

  always_ff @(posedge clk) begin
    if (en) begin
      s_fin <= sm[60:30];
      s_p1  <= s_fin;
      s_p2  <= s_p1;
    end
  end

  // quadrant fold and scale multiply
  logic [1:0]        qf;
  logic              swap;
  logic [TRIG_W-1:0] re_mag;
  logic [TRIG_W-1:0] im_mag;
  logic [MP_W-1:0]   re_prod;
  logic [MP_W-1:0]   im_prod;
  logic              re_neg;
  logic              im_neg;
  logic              em;

  assign qf     = q_dly[TRIG_LAT-1];
  assign swap   = qf[0];
  assign re_mag = swap ? s_p2 : cos_t[COS_TERMS];
  assign im_mag = swap ? cos_t[COS_TERMS] : s_p2;

  always_ff @(posedge clk) begin
    if (en) begin
      re_prod <= {{SCALE_W{1'b0}}, re_mag} * {{TRIG_W{1'b0}}, norm_scale};
      im_prod <= {{SCALE_W{1'b0}}, im_mag} * {{TRIG_W{1'b0}}, norm_scale};
      re_neg  <= qf[1] ^ qf[0];
      im_neg  <= !qf[1];
      em      <= e_dly[TRIG_LAT-1];
    end
  end

  // rounding, saturation and sign
  logic [MP_W:0]          re_sum;
  logic [MP_W:0]          im_sum;
  logic [MAG_W-1:0]       re_m;
  logic [MAG_W-1:0]       im_m;
  logic [SAMPLE_BITS-1:0] re_v;
  logic [SAMPLE_BITS-1:0] im_v;

  always_comb begin
    re_sum = {1'b0, re_prod} + RND;
    im_sum = {1'b0, im_prod} + RND;
    re_m   = re_sum[MP_W:SH];
    im_m   = im_sum[MP_W:SH];
    if (re_m > OUT_MAX) re_m = OUT_MAX;
    if (im_m > OUT_MAX) im_m = OUT_MAX;
    re_v = re_neg ? SAMPLE_BITS'(-re_m) : re_m[SAMPLE_BITS-1:0];
    im_v = im_neg ? SAMPLE_BITS'(-im_m) : im_m[SAMPLE_BITS-1:0];
    if (em) begin
      re_v = '0;
      im_v = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.real_part   <= $signed(re_v);
      rsp.imag_part   <= $signed(im_v);
      rsp.index_error <= em;
    end
  end

endmodule

/* hdl/dft_matrix_entry_generator.sv */
// ----------------------------------------------------------------------------
// dft_matrix_entry_generator
// Throughput one index pair per cycle while rsp.ready does not stall the output,
// through the 40 step pipelined divider and the 21 stage series pipeline.
// Reset clears all valid state, size_n to 1 and norm_scale to 32767.
// ----------------------------------------------------------------------------
module dft_matrix_entry_generator import dftme_pkg::*; #(
  parameter int MAX_ORDER   = DEF_MAX_ORDER,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  dftme_in_if.sink    req,
  dftme_out_if.source rsp,
  dftme_cfg_if.sink   cfg
);

  localparam int N_CAP = (MAX_ORDER > (2**N_W - 1)) ? (2**N_W - 1) : MAX_ORDER;

  logic [N_W-1:0]     size_n;
  logic [SCALE_W-1:0] norm_scale;
  logic [N_W-1:0]     n_eff;
  item_t              f_item;
  logic               f_valid;
  logic               f_ready;
  item_t              b_item;
  logic               b_valid;
  logic               b_ready;

  assign cfg.ready = 1'b1;
  assign n_eff     = (size_n > N_W'(N_CAP)) ? N_W'(N_CAP) : size_n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_n     <= N_W'(1);
      norm_scale <= '1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SIZE_N:     size_n     <= cfg.data[N_W-1:0];
        CFG_NORM_SCALE: norm_scale <= cfg.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  dftme_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .n_eff      (n_eff),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  dftme_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (b_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  dftme_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .norm_scale (norm_scale),
    .item       (b_item),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .rsp        (rsp)
  );

endmodule
